/* rtl/kwdt_pkg.sv */
// Shared types and constants for the keyed watchdog timer.
package kwdt_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] REG_CTRL    = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_WINDOW  = 2'd3;

    localparam logic [31:0] KEY_UNLOCK  = 32'hD928_C520;
    localparam logic [31:0] KEY_REFRESH = 32'hB480_A602;

    localparam int CTRL_UPDATE   = 5;
    localparam int CTRL_ENABLE   = 7;
    localparam int CTRL_CLKSEL   = 8;
    localparam int CTRL_RECONFIG = 10;
    localparam int CTRL_UNLOCKED = 11;
    localparam int CTRL_PRESCALE = 12;
    localparam int CTRL_CMD32    = 13;
    localparam int CTRL_FLAG     = 14;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;
    localparam int PRE_W   = 8;
    localparam int WIN_W   = 8;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              timeout_reset;
        logic              write_ignored;
    } t_result;

endpackage

/* rtl/keyed_watchdog_timer.sv */
// A transaction is held in the input register, and its result is then held in the result register.
// Throughput: one transaction per cycle unless the result port stalls, set by the single
// register-to-register update of the watchdog state between the input and result registers.
// The result register holds under backpressure while the input register still takes one more.
// Reset (synchronous, active low) empties both registers and restores all watchdog registers.
module keyed_watchdog_timer
    import kwdt_pkg::*;
#(
    parameter int UNLOCK_WINDOW  = 255,
    parameter int PRESCALE_RATIO = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [31:0] write_data
    input  logic [DATA_W-1:0]      i_s_axis_tdata,
    // [1:0] func, [3:2] reg_index
    input  logic [3:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] read_data, [32] timeout_reset, [33] write_ignored, [39:34] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    logic    fire;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.func       <= i_s_axis_tuser[1:0];
            r_item.reg_index  <= i_s_axis_tuser[3:2];
            r_item.write_data <= i_s_axis_tdata;
        end
    end

    kwdt_core #(
        .UNLOCK_WINDOW  (UNLOCK_WINDOW),
        .PRESCALE_RATIO (PRESCALE_RATIO)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_result.write_ignored, r_result.timeout_reset,
                              r_result.read_data};

endmodule

/* rtl/kwdt_core.sv */
// Watchdog register file, unlock sequencing and counter update for one transaction.
module kwdt_core
    import kwdt_pkg::*;
#(
    parameter int UNLOCK_WINDOW  = 255,
    parameter int PRESCALE_RATIO = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [PRE_W-1:0] PreLast    = PRE_W'(PRESCALE_RATIO - 1);
    localparam logic [WIN_W-1:0] WindowLoad = WIN_W'(UNLOCK_WINDOW);

    logic               r_enable, n_enable;
    logic               r_update, n_update;
    logic               r_prescale, n_prescale;
    logic               r_cmd32, n_cmd32;
    logic [1:0]         r_clksel, n_clksel;
    logic               r_unlocked, n_unlocked;
    logic               r_reconfig, n_reconfig;
    logic               r_flag, n_flag;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_timeout, n_timeout;
    logic [COUNT_W-1:0] r_window, n_window;
    logic [PRE_W-1:0]   r_pre_cnt, n_pre_cnt;
    logic [WIN_W-1:0]   r_win_left, n_win_left;

    logic [DATA_W-1:0] ctrl_word;
    logic              advance;

    always_comb begin
        ctrl_word = '0;
        ctrl_word[CTRL_UPDATE]            = r_update;
        ctrl_word[CTRL_ENABLE]            = r_enable;
        ctrl_word[CTRL_CLKSEL+1:CTRL_CLKSEL] = r_clksel;
        ctrl_word[CTRL_RECONFIG]          = r_reconfig;
        ctrl_word[CTRL_UNLOCKED]          = r_unlocked;
        ctrl_word[CTRL_PRESCALE]          = r_prescale;
        ctrl_word[CTRL_CMD32]             = r_cmd32;
        ctrl_word[CTRL_FLAG]              = r_flag;
    end

    always_comb begin
        n_enable   = r_enable;
        n_update   = r_update;
        n_prescale = r_prescale;
        n_cmd32    = r_cmd32;
        n_clksel   = r_clksel;
        n_unlocked = r_unlocked;
        n_reconfig = r_reconfig;
        n_flag     = r_flag;
        n_count    = r_count;
        n_timeout  = r_timeout;
        n_window   = r_window;
        n_pre_cnt  = r_pre_cnt;
        n_win_left = r_win_left;
        advance    = 1'b0;
        o_result   = '0;

        unique case (i_item.func)
            FUNC_TICK: begin
                if (r_unlocked) begin
                    n_win_left = r_win_left - 1'b1;
                    if (n_win_left == '0) begin
                        n_unlocked = 1'b0;
                    end
                end
                if (r_enable) begin
                    advance = 1'b1;
                    if (r_prescale) begin
                        if (r_pre_cnt >= PreLast) begin
                            n_pre_cnt = '0;
                        end else begin
                            n_pre_cnt = r_pre_cnt + 1'b1;
                            advance   = 1'b0;
                        end
                    end
                end
                if (advance) begin
                    if (r_count >= r_timeout) begin
                        n_flag   = 1'b1;
                        n_count  = '0;
                        o_result.timeout_reset = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            FUNC_WRITE: begin
                if (i_item.reg_index == REG_COUNT) begin
                    if (i_item.write_data == KEY_UNLOCK) begin
                        n_unlocked = 1'b1;
                        n_win_left = WindowLoad;
                        n_reconfig = 1'b0;
                    end else if (i_item.write_data == KEY_REFRESH && r_cmd32) begin
                        n_count = '0;
                    end
                end else if (!r_unlocked) begin
                    o_result.write_ignored = 1'b1;
                end else begin
                    if (i_item.reg_index == REG_CTRL) begin
                        n_update   = i_item.write_data[CTRL_UPDATE];
                        n_enable   = i_item.write_data[CTRL_ENABLE];
                        n_clksel   = i_item.write_data[CTRL_CLKSEL+1:CTRL_CLKSEL];
                        n_prescale = i_item.write_data[CTRL_PRESCALE];
                        n_cmd32    = i_item.write_data[CTRL_CMD32];
                        if (i_item.write_data[CTRL_FLAG]) begin
                            n_flag = 1'b0;
                        end
                    end else if (i_item.reg_index == REG_TIMEOUT) begin
                        n_timeout = i_item.write_data[COUNT_W-1:0];
                    end else begin
                        n_window = i_item.write_data[COUNT_W-1:0];
                    end
                    n_reconfig = 1'b1;
                    n_unlocked = 1'b0;
                    n_win_left = '0;
                end
            end
            FUNC_READ: begin
                unique case (i_item.reg_index)
                    REG_CTRL:    o_result.read_data = ctrl_word;
                    REG_COUNT:   o_result.read_data = DATA_W'(r_count);
                    REG_TIMEOUT: o_result.read_data = DATA_W'(r_timeout);
                    REG_WINDOW:  o_result.read_data = DATA_W'(r_window);
                    default:     o_result.read_data = '0;
                endcase
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_update   <= 1'b1;
            r_prescale <= 1'b0;
            r_cmd32    <= 1'b1;
            r_clksel   <= '0;
            r_unlocked <= 1'b0;
            r_reconfig <= 1'b0;
            r_flag     <= 1'b0;
            r_count    <= '0;
            r_timeout  <= '1;
            r_window   <= '0;
            r_pre_cnt  <= '0;
            r_win_left <= '0;
        end else if (i_fire) begin
            r_enable   <= n_enable;
            r_update   <= n_update;
            r_prescale <= n_prescale;
            r_cmd32    <= n_cmd32;
            r_clksel   <= n_clksel;
            r_unlocked <= n_unlocked;
            r_reconfig <= n_reconfig;
            r_flag     <= n_flag;
            r_count    <= n_count;
            r_timeout  <= n_timeout;
            r_window   <= n_window;
            r_pre_cnt  <= n_pre_cnt;
            r_win_left <= n_win_left;
        end
    end

endmodule

/* rtl/keyed_watchdog_timer_sva.sv */
// Port-level checker for the keyed watchdog timer and its bind.
module keyed_watchdog_timer_sva
    import kwdt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Result changed or dropped while stalled.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[32] && o_m_axis_tdata[33]))
        else $error("Timeout and ignored write flagged in one transaction.");

    a_read_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[31:0] != 32'd0) |->
            (o_m_axis_tdata[33:32] == 2'b00))
        else $error("Read data returned together with a flag.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[39:34] == 6'd0))
        else $error("Padding bits of the result are not zero.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind keyed_watchdog_timer keyed_watchdog_timer_sva u_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the keyed watchdog timer, driven and checked over its streams.
module testbench;
    import kwdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_TICKS   = 255;
    localparam int PRESCALE_TICKS = 256;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [31:0] write_data
    logic [DATA_W-1:0]      i_s_axis_tdata = '0;
    // [1:0] func, [3:2] reg_index
    logic [3:0]             i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [31:0] read_data, [32] timeout_reset, [33] write_ignored, [39:34] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    keyed_watchdog_timer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    logic               wd_enable = 1'b0;
    logic               wd_update = 1'b1;
    logic               wd_prescale = 1'b0;
    logic               wd_cmd32 = 1'b1;
    logic [1:0]         wd_clksel = 2'd0;
    logic               wd_unlocked = 1'b0;
    logic               wd_reconfig = 1'b0;
    logic               wd_flag = 1'b0;
    logic [COUNT_W-1:0] wd_count = '0;
    logic [COUNT_W-1:0] wd_timeout = '1;
    logic [COUNT_W-1:0] wd_window = '0;
    logic [PRE_W-1:0]   wd_prescale_cnt = '0;
    logic [WIN_W-1:0]   wd_unlock_left = '0;

    t_result watchdog_results[$];
    t_result oldest_result;
    int      error_count = 0;
    int      items_sent = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;

    function automatic t_result watchdog_step(input logic [1:0] f, input logic [1:0] r,
                                              input logic [DATA_W-1:0] d);
        t_result res;
        logic    advance;
        res = '0;
        case (f)
            FUNC_TICK: begin
                if (wd_unlocked) begin
                    wd_unlock_left = wd_unlock_left - 1'b1;
                    if (wd_unlock_left == '0) wd_unlocked = 1'b0;
                end
                if (wd_enable) begin
                    advance = 1'b1;
                    if (wd_prescale) begin
                        if (wd_prescale_cnt >= PRESCALE_TICKS - 1) begin
                            wd_prescale_cnt = '0;
                        end else begin
                            wd_prescale_cnt = wd_prescale_cnt + 1'b1;
                            advance = 1'b0;
                        end
                    end
                    if (advance) begin
                        if (wd_count >= wd_timeout) begin
                            wd_flag = 1'b1;
                            wd_count = '0;
                            res.timeout_reset = 1'b1;
                        end else begin
                            wd_count = wd_count + 1'b1;
                        end
                    end
                end
            end
            FUNC_WRITE: begin
                if (r == REG_COUNT) begin
                    if (d == KEY_UNLOCK) begin
                        wd_unlocked = 1'b1;
                        wd_unlock_left = WIN_W'(WINDOW_TICKS);
                        wd_reconfig = 1'b0;
                    end else if (d == KEY_REFRESH && wd_cmd32) begin
                        wd_count = '0;
                    end
                end else if (!wd_unlocked) begin
                    res.write_ignored = 1'b1;
                end else begin
                    case (r)
                        REG_CTRL: begin
                            wd_update   = d[CTRL_UPDATE];
                            wd_enable   = d[CTRL_ENABLE];
                            wd_clksel   = d[CTRL_CLKSEL +: 2];
                            wd_prescale = d[CTRL_PRESCALE];
                            wd_cmd32    = d[CTRL_CMD32];
                            if (d[CTRL_FLAG]) wd_flag = 1'b0;
                        end
                        REG_TIMEOUT: wd_timeout = d[COUNT_W-1:0];
                        default:     wd_window = d[COUNT_W-1:0];
                    endcase
                    wd_reconfig = 1'b1;
                    wd_unlocked = 1'b0;
                    wd_unlock_left = '0;
                end
            end
            FUNC_READ: begin
                case (r)
                    REG_CTRL: begin
                        res.read_data[CTRL_UPDATE]   = wd_update;
                        res.read_data[CTRL_ENABLE]   = wd_enable;
                        res.read_data[CTRL_CLKSEL +: 2] = wd_clksel;
                        res.read_data[CTRL_RECONFIG] = wd_reconfig;
                        res.read_data[CTRL_UNLOCKED] = wd_unlocked;
                        res.read_data[CTRL_PRESCALE] = wd_prescale;
                        res.read_data[CTRL_CMD32]    = wd_cmd32;
                        res.read_data[CTRL_FLAG]     = wd_flag;
                    end
                    REG_COUNT:   res.read_data[COUNT_W-1:0] = wd_count;
                    REG_TIMEOUT: res.read_data[COUNT_W-1:0] = wd_timeout;
                    default:     res.read_data[COUNT_W-1:0] = wd_window;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [1:0] r,
                             input logic [DATA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= {r, f};
        watchdog_results.push_back(watchdog_step(f, r, d));
        items_sent++;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(FUNC_TICK, 2'($urandom()), $urandom());
    endtask

    task automatic test_reset_values();
        send_item(FUNC_READ, REG_CTRL, $urandom());
        send_item(FUNC_READ, REG_COUNT, $urandom());
        send_item(FUNC_READ, REG_TIMEOUT, $urandom());
        send_item(FUNC_READ, REG_WINDOW, $urandom());
    endtask

    task automatic test_locked_writes();
        send_item(FUNC_WRITE, REG_CTRL, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE, REG_TIMEOUT, 32'h0000_0000);
        send_item(FUNC_WRITE, REG_WINDOW, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE, REG_COUNT, 32'h1234_5678);
    endtask

    task automatic test_unlock_and_reconfigure();
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_TIMEOUT, 32'hABCD_0003);
        send_item(FUNC_WRITE, REG_TIMEOUT, 32'h0000_0007);
        send_item(FUNC_READ, REG_TIMEOUT, $urandom());
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_CTRL, 32'hFFFF_EFFF);
        send_item(FUNC_READ, REG_CTRL, $urandom());
    endtask

    task automatic test_timeout();
        send_ticks(4);
        send_item(FUNC_READ, REG_CTRL, $urandom());
        send_ticks(2);
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_TIMEOUT, 32'h0000_0000);
        send_ticks(1);
        send_item(FUNC_READ, REG_COUNT, $urandom());
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_TIMEOUT, 32'h0000_0005);
    endtask

    task automatic test_refresh();
        send_ticks(2);
        send_item(FUNC_WRITE, REG_COUNT, KEY_REFRESH);
        send_item(FUNC_READ, REG_COUNT, $urandom());
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_CTRL, 32'h0000_0080);
        send_ticks(1);
        send_item(FUNC_WRITE, REG_COUNT, KEY_REFRESH);
        send_item(FUNC_READ, REG_COUNT, $urandom());
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_CTRL, 32'h0000_20A0);
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_WRITE, REG_WINDOW, 32'hFFFF_FFFF);
        send_item(FUNC_READ, REG_WINDOW, $urandom());
    endtask

    task automatic test_unused_func();
        send_item(FUNC_UNUSED, REG_COUNT, KEY_UNLOCK);
        send_item(FUNC_UNUSED, REG_CTRL, 32'hFFFF_FFFF);
        send_item(FUNC_READ, REG_CTRL, $urandom());
    endtask

    task automatic test_unlock_expiry();
        send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
        send_ticks(WINDOW_TICKS - 1);
        send_item(FUNC_READ, REG_CTRL, $urandom());
        send_ticks(1);
        send_item(FUNC_READ, REG_CTRL, $urandom());
        send_item(FUNC_WRITE, REG_WINDOW, $urandom());
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        int                stop_at;
        logic [1:0]        r;
        logic [DATA_W-1:0] d;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
                    if ($urandom_range(7) == 0) send_item(FUNC_WRITE, REG_COUNT, KEY_UNLOCK);
                    repeat ($urandom_range(3))
                        send_item($urandom_range(1) ? FUNC_TICK : FUNC_READ,
                                  2'($urandom()), $urandom());
                    d = $urandom();
                    case ($urandom_range(2))
                        0: begin
                            r = REG_CTRL;
                            d[CTRL_PRESCALE] = ($urandom_range(3) == 0);
                            d[CTRL_ENABLE] = ($urandom_range(3) != 0);
                        end
                        1: begin
                            r = REG_TIMEOUT;
                            if ($urandom_range(7) != 0)
                                d[COUNT_W-1:0] = COUNT_W'($urandom_range(40));
                        end
                        default: r = REG_WINDOW;
                    endcase
                    send_item(FUNC_WRITE, r, d);
                end
                4, 5: send_ticks(($urandom_range(15) == 0) ? $urandom_range(300, 260)
                                                           : $urandom_range(40, 1));
                6: send_item(FUNC_READ, 2'($urandom()), $urandom());
                7: send_item(FUNC_WRITE, REG_COUNT, $urandom_range(1) ? KEY_REFRESH : $urandom());
                8: send_item(FUNC_WRITE, 2'($urandom_range(2) == 0 ? REG_CTRL :
                                            $urandom_range(1) ? REG_TIMEOUT : REG_WINDOW),
                             $urandom());
                default: send_item(2'($urandom_range(2)), 2'($urandom()), $urandom());
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (watchdog_results.size() == 0) begin
                $error("result transaction with no expectation: tdata %h", o_m_axis_tdata);
                error_count++;
            end else begin
                oldest_result = watchdog_results.pop_front();
                if (o_m_axis_tdata[31:0] !== oldest_result.read_data) begin
                    $error("read_data expected %h actual %h",
                           oldest_result.read_data, o_m_axis_tdata[31:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[32] !== oldest_result.timeout_reset) begin
                    $error("timeout_reset expected %b actual %b",
                           oldest_result.timeout_reset, o_m_axis_tdata[32]);
                    error_count++;
                end
                if (o_m_axis_tdata[33] !== oldest_result.write_ignored) begin
                    $error("write_ignored expected %b actual %b",
                           oldest_result.write_ignored, o_m_axis_tdata[33]);
                    error_count++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_locked_writes();
        test_unlock_and_reconfigure();
        test_timeout();
        test_refresh();
        test_unused_func();
        src_idle_pct = 8;
        sink_stall_pct = 8;
        test_unlock_expiry();
        test_random_traffic(190, 0, 0);
        test_random_traffic(190, 52, 0);
        test_random_traffic(190, 0, 52);
        test_random_traffic(190, 8, 8);
        i_s_axis_tvalid <= 1'b0;
        while (watchdog_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* keyed_watchdog_timer.f */
rtl/kwdt_pkg.sv
rtl/kwdt_core.sv
rtl/keyed_watchdog_timer.sv
rtl/keyed_watchdog_timer_sva.sv
tb/sv/testbench.sv
